// ===== rtl/core/char_stream_tokenizer_unit_assert.svh =====
// Assertion macros for the tokenizer; empty when built for synthesis.
`ifndef CHAR_STREAM_TOKENIZER_UNIT_ASSERT_SVH
`define CHAR_STREAM_TOKENIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is active
`define CSTU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// Next-cycle implication, disabled while reset is active
`define CSTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`else

`define CSTU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CSTU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/cst_pkg.sv =====
package cst_pkg;

    // Tokenizer mode
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_STRING,
        MODE_ESCAPE
    } cst_mode_t;

    // Token kinds; punctuation follows in table order
    typedef enum logic [4:0] {
        KIND_UNKNOWN, KIND_WORD, KIND_STRING, KIND_EOF,
        KIND_PLUS, KIND_MINUS, KIND_EQUAL, KIND_STAR, KIND_SLASH, KIND_BACKSLASH,
        KIND_LBRACE, KIND_RBRACE, KIND_LPAREN, KIND_RPAREN, KIND_SEMI, KIND_DOT,
        KIND_COMMA, KIND_LESS, KIND_GREATER, KIND_BANG, KIND_AMP, KIND_PIPE,
        KIND_PERCENT, KIND_CARET, KIND_COLON, KIND_TILDE
    } cst_kind_t;

    // Byte constants
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_VT      = 8'd11;
    localparam logic [7:0] CH_FF      = 8'd12;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_ESC     = 8'd27;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TILDE   = 8'd126;
    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_BEL     = 8'd7;
    localparam logic [7:0] CH_BS      = 8'd8;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_FSLASH  = 8'h2F;

    // One result item
    typedef struct packed {
        cst_kind_t  kind;
        logic [7:0] data_byte;
        logic       is_char;
        logic       token_end;
        logic       error;
    } cst_result_t;

    // Results of one input item
    typedef struct packed {
        cst_result_t res0;
        cst_result_t res1;
        logic [1:0]  count;
    } cst_step_t;

    // Idle handling of one byte or end mark
    typedef struct packed {
        logic        has;
        cst_result_t res;
        cst_mode_t   mode;
    } cst_idle_t;

    function automatic cst_result_t cst_make(cst_kind_t kind, logic [7:0] data_byte,
                                             logic is_char, logic token_end, logic error);
        cst_result_t r;
        r.kind      = kind;
        r.data_byte = data_byte;
        r.is_char   = is_char;
        r.token_end = token_end;
        r.error     = error;
        return r;
    endfunction

    function automatic logic cst_is_alnum(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic cst_is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic cst_is_print(logic [7:0] c);
        return (c >= CH_SPACE) && (c <= CH_TILDE);
    endfunction

    // Punctuation lookup; anything else is unknown
    function automatic cst_kind_t cst_punct_kind(logic [7:0] c);
        cst_kind_t k;
        unique case (c)
            "+":       k = KIND_PLUS;
            "-":       k = KIND_MINUS;
            "=":       k = KIND_EQUAL;
            "*":       k = KIND_STAR;
            "/":       k = KIND_SLASH;
            CH_BSLASH: k = KIND_BACKSLASH;
            "{":       k = KIND_LBRACE;
            "}":       k = KIND_RBRACE;
            "(":       k = KIND_LPAREN;
            ")":       k = KIND_RPAREN;
            ";":       k = KIND_SEMI;
            ".":       k = KIND_DOT;
            ",":       k = KIND_COMMA;
            "<":       k = KIND_LESS;
            ">":       k = KIND_GREATER;
            "!":       k = KIND_BANG;
            "&":       k = KIND_AMP;
            "|":       k = KIND_PIPE;
            "%":       k = KIND_PERCENT;
            "^":       k = KIND_CARET;
            ":":       k = KIND_COLON;
            "~":       k = KIND_TILDE;
            default:   k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // Handle a byte or end mark from idle
    function automatic cst_idle_t cst_idle(logic [7:0] c, logic eoi);
        cst_idle_t o;
        o.has  = 1'b1;
        o.mode = MODE_IDLE;
        o.res  = cst_make(KIND_UNKNOWN, CH_NUL, 1'b0, 1'b1, 1'b0);
        priority if (eoi)
        begin
            o.res = cst_make(KIND_EOF, CH_NUL, 1'b0, 1'b1, 1'b0);
        end
        else if (cst_is_space(c))
        begin
            o.has = 1'b0;
        end
        else if (cst_is_alnum(c))
        begin
            o.mode = MODE_WORD;
            o.res  = cst_make(KIND_WORD, c, 1'b1, 1'b0, 1'b0);
        end
        else if (c == CH_QUOTE)
        begin
            o.has  = 1'b0;
            o.mode = MODE_STRING;
        end
        else
        begin
            o.res = cst_make(cst_punct_kind(c), CH_NUL, 1'b0, 1'b1, 1'b0);
        end
        return o;
    endfunction

endpackage

// ===== rtl/core/char_stream_tokenizer_unit.sv =====
// Streaming character tokenizer.
// Input channel s_axis: one source byte per transaction in tdata; tuser set marks
// end of input, and the byte is then ignored. Output channel m_axis: one token
// result per transaction. tdata carries a word or string character, tuser the
// token kind and flags, tlast marks the result that completes a token.
// An input transaction lands in an input register; from there its first result
// is loaded into the output register, which drives m_axis. Bytes with one or no
// result are taken one per cycle while m_axis does not stall. A byte that ends a
// word and gives a result of its own (punctuation or end mark) gives two results
// and holds the input register until both have gone to the single output register.
// Whitespace and an opening quote outside a token, a dropped string byte and the
// escape lead-in give no result and leave without waiting on m_axis. When m_axis
// stalls, the output register holds its result, the input register fills behind
// it and s_axis_tready drops. Reset empties both registers and returns the mode to idle.
module char_stream_tokenizer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] ch
    input  logic [0:0] s_axis_tuser,  // [0] end_of_input
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] data_byte
    output logic [7:0] m_axis_tuser,  // [4:0] kind, [5] is_char, [6] error, [7] run_last
    output logic       m_axis_tlast   // token_end
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [7:0]           ch_reg;
    logic                 eoi_reg;
    logic                 idx_reg;
    logic                 idx_next;
    cst_pkg::cst_mode_t   mode_reg;
    cst_pkg::cst_mode_t   mode_after;
    cst_pkg::cst_mode_t   mode_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    cst_pkg::cst_result_t out_res_reg;
    logic                 out_last_reg;
    cst_pkg::cst_step_t   step;
    logic                 out_free;
    logic                 cur_last;
    logic                 emit;
    logic                 consume;

    // Work out the results of the held byte
    cst_decode u_decode (
        .mode         (mode_reg),
        .ch           (ch_reg),
        .end_of_input (eoi_reg),
        .step         (step),
        .mode_next    (mode_after)
    );

    // Handshake control
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cur_last      = (step.count == 2'd1) || idx_reg;
    assign emit          = in_valid_reg && (step.count != 2'd0) && out_free;
    assign consume       = in_valid_reg && ((step.count == 2'd0) || (out_free && cur_last));
    assign s_axis_tready = !in_valid_reg || consume;

    // Next control state
    always_comb
    begin
        in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
        idx_next       = consume ? 1'b0 : (emit ? 1'b1 : idx_reg);
        mode_next      = consume ? mode_after : mode_reg;
        out_valid_next = emit ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            idx_reg       <= 1'b0;
            mode_reg      <= cst_pkg::MODE_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            idx_reg       <= idx_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input byte and load the output result
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            ch_reg  <= s_axis_tdata;
            eoi_reg <= s_axis_tuser[0];
        end
        if (emit)
        begin
            out_res_reg  <= idx_reg ? step.res1 : step.res0;
            out_last_reg <= cur_last;
        end
    end

    // Drive the output channel
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg.data_byte;
    assign m_axis_tuser  = {out_last_reg, out_res_reg.error, out_res_reg.is_char,
                            out_res_reg.kind};
    assign m_axis_tlast  = out_res_reg.token_end;

`include "char_stream_tokenizer_unit_assert.svh"

    `CSTU_ASSERT_IMPL(a_second_needs_two, clk, rst_n, idx_reg,
                      in_valid_reg && step.count == 2'd2)
    `CSTU_ASSERT_NEXT(a_mode_holds, clk, rst_n, !consume, $stable(mode_reg))
    `CSTU_ASSERT_IMPL(a_open_is_char, clk, rst_n,
                      out_valid_reg && !out_res_reg.token_end, out_res_reg.is_char)
    `CSTU_ASSERT_IMPL(a_err_closes_string, clk, rst_n, out_valid_reg && out_res_reg.error,
                      out_res_reg.token_end && out_res_reg.kind == cst_pkg::KIND_STRING)

endmodule

// ===== rtl/core/cst_decode.sv =====
module cst_decode (
    input  cst_pkg::cst_mode_t mode,
    input  logic [7:0]         ch,
    input  logic               end_of_input,
    output cst_pkg::cst_step_t step,
    output cst_pkg::cst_mode_t mode_next
);

    cst_pkg::cst_idle_t idle;
    logic               alnum;

    assign idle  = cst_pkg::cst_idle(ch, end_of_input);
    assign alnum = !end_of_input && cst_pkg::cst_is_alnum(ch);

    // Next mode
    always_comb
    begin
        mode_next = mode;
        unique case (mode)
            cst_pkg::MODE_IDLE:
            begin
                mode_next = idle.mode;
            end
            cst_pkg::MODE_WORD:
            begin
                if (!alnum)
                begin
                    mode_next = idle.mode;
                end
            end
            cst_pkg::MODE_STRING:
            begin
                priority if (end_of_input || ch == cst_pkg::CH_QUOTE)
                begin
                    mode_next = cst_pkg::MODE_IDLE;
                end
                else if (ch == cst_pkg::CH_BSLASH)
                begin
                    mode_next = cst_pkg::MODE_ESCAPE;
                end
                else
                begin
                    mode_next = cst_pkg::MODE_STRING;
                end
            end
            cst_pkg::MODE_ESCAPE:
            begin
                if (end_of_input)
                begin
                    mode_next = cst_pkg::MODE_IDLE;
                end
                else
                begin
                    unique case (ch)
                        "0", "a", "b", "t", "n", "v", "f", "r", "e",
                        cst_pkg::CH_QUOTE, cst_pkg::CH_FSLASH:
                            mode_next = cst_pkg::MODE_STRING;
                        default:
                            mode_next = cst_pkg::MODE_IDLE;
                    endcase
                end
            end
            default:
            begin
                mode_next = cst_pkg::MODE_IDLE;
            end
        endcase
    end

    // Result items
    always_comb
    begin
        step.res0  = cst_pkg::cst_make(cst_pkg::KIND_UNKNOWN, cst_pkg::CH_NUL,
                                       1'b0, 1'b0, 1'b0);
        step.res1  = step.res0;
        step.count = 2'd0;
        unique case (mode)
            cst_pkg::MODE_IDLE:
            begin
                step.res0  = idle.res;
                step.count = {1'b0, idle.has};
            end
            cst_pkg::MODE_WORD:
            begin
                if (alnum)
                begin
                    step.res0  = cst_pkg::cst_make(cst_pkg::KIND_WORD, ch, 1'b1, 1'b0, 1'b0);
                    step.count = 2'd1;
                end
                else
                begin
                    // close the word, then handle the ending byte from idle
                    step.res0  = cst_pkg::cst_make(cst_pkg::KIND_WORD, cst_pkg::CH_NUL,
                                                   1'b0, 1'b1, 1'b0);
                    step.res1  = idle.res;
                    step.count = idle.has ? 2'd2 : 2'd1;
                end
            end
            cst_pkg::MODE_STRING:
            begin
                priority if (end_of_input)
                begin
                    step.res0  = cst_pkg::cst_make(cst_pkg::KIND_STRING, cst_pkg::CH_NUL,
                                                   1'b0, 1'b1, 1'b1);
                    step.count = 2'd1;
                end
                else if (ch == cst_pkg::CH_QUOTE)
                begin
                    step.res0  = cst_pkg::cst_make(cst_pkg::KIND_STRING, cst_pkg::CH_NUL,
                                                   1'b0, 1'b1, 1'b0);
                    step.count = 2'd1;
                end
                else if (ch != cst_pkg::CH_BSLASH && cst_pkg::cst_is_print(ch))
                begin
                    step.res0  = cst_pkg::cst_make(cst_pkg::KIND_STRING, ch,
                                                   1'b1, 1'b0, 1'b0);
                    step.count = 2'd1;
                end
                else
                begin
                    // drop: escape lead-in or unprintable byte
                    step.count = 2'd0;
                end
            end
            cst_pkg::MODE_ESCAPE:
            begin
                step.count = 2'd1;
                step.res0  = cst_pkg::cst_make(cst_pkg::KIND_STRING, cst_pkg::CH_NUL,
                                               1'b1, 1'b0, 1'b0);
                if (end_of_input)
                begin
                    step.res0 = cst_pkg::cst_make(cst_pkg::KIND_STRING, cst_pkg::CH_NUL,
                                                  1'b0, 1'b1, 1'b1);
                end
                else
                begin
                    unique case (ch)
                        "0":               step.res0.data_byte = cst_pkg::CH_NUL;
                        "a":               step.res0.data_byte = cst_pkg::CH_BEL;
                        "b":               step.res0.data_byte = cst_pkg::CH_BS;
                        "t":               step.res0.data_byte = cst_pkg::CH_TAB;
                        "n":               step.res0.data_byte = cst_pkg::CH_LF;
                        "v":               step.res0.data_byte = cst_pkg::CH_VT;
                        "f":               step.res0.data_byte = cst_pkg::CH_FF;
                        "r":               step.res0.data_byte = cst_pkg::CH_CR;
                        "e":               step.res0.data_byte = cst_pkg::CH_ESC;
                        cst_pkg::CH_QUOTE: step.res0.data_byte = cst_pkg::CH_QUOTE;
                        cst_pkg::CH_FSLASH:
                        begin
                            step.count = 2'd0;
                        end
                        default:
                        begin
                            step.res0 = cst_pkg::cst_make(cst_pkg::KIND_STRING,
                                                          cst_pkg::CH_NUL,
                                                          1'b0, 1'b1, 1'b1);
                        end
                    endcase
                end
            end
            default:
            begin
                step.count = 2'd0;
            end
        endcase
    end

endmodule
